>>> rtl/edsl_pkg.sv
// Shared constants for the edge-driven set labeling block.
// Holds default sizes, stream word widths, register reset value and result action codes.
// No dependencies.
`default_nettype none

package edsl_pkg;

  localparam int unsigned NODES_DEF  = 1024;
  localparam int unsigned GROUPS_DEF = 512;

  localparam int unsigned CFG_W        = 11;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam int unsigned NODE_ID_W    = 10;
  localparam int unsigned IN_TDATA_W   = 24;

  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned SET_ID_W     = 9;
  localparam int unsigned SET_SIZE_W   = 11;
  localparam int unsigned LIVE_SETS_W  = 10;
  localparam int unsigned OUT_TDATA_W  = 40;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NEW   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_JOIN  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_MERGE = 2'd3;

endpackage

`default_nettype wire

>>> rtl/edge_driven_set_labeling.sv
// Top level of the edge-driven set labeling block (quick-find union-find).
// Node labels and set sizes live in two memories with registered read data.
// Depends on edsl_pkg.
//
// channel    | dir | fields (lowest bit first)
// s_axis     | in  | node_a[9:0], node_b[19:10]
// m_axis     | out | action[1:0], set_id[10:2], set_size[21:11], live_sets[31:22],
//            |     | all_joined[32]
// cfg        | in  | node_count[10:0]
//
// An edge that names a set runs a full walk over the node label memory (one read
// port, one write port) that checks the all-joined condition and relabels the
// source set on a merge; an ignored edge skips the walk. After reset a clearing
// pass over the node label memory marks every node unlabeled; no word is taken
// until it ends. A finished result waits in the output register while the next
// edge is processed; only the final load stalls on m_axis.
`default_nettype none

module edge_driven_set_labeling #(
  parameter int unsigned NODES  = edsl_pkg::NODES_DEF,
  parameter int unsigned GROUPS = edsl_pkg::GROUPS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // node_a[9:0], node_b[19:10], zero fill above
  input  wire logic [edsl_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // action[1:0], set_id[10:2], set_size[21:11], live_sets[31:22], all_joined[32]
  output logic [edsl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [edsl_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import edsl_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned GW = $clog2(GROUPS);
  localparam int unsigned LW = GW + 1;
  localparam int unsigned SW = NW + 1;
  localparam int unsigned CW = (NW > CFG_W) ? NW : CFG_W;
  localparam logic [NW-1:0] LAST_IDX = NW'(NODES - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_WRB   = 4'd4;
  localparam logic [3:0] S_GSRC  = 4'd5;
  localparam logic [3:0] S_GSZ   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [LW-1:0] node_mem [NODES];
  logic [SW-1:0] grp_mem [GROUPS];

  logic          nm_we;
  logic [NW-1:0] nm_waddr, nm_raddr;
  logic [LW-1:0] nm_wdata, nm_rdata_q;
  logic          gm_we;
  logic [GW-1:0] gm_waddr, gm_raddr;
  logic [SW-1:0] gm_wdata, gm_rdata_q;

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] pidx_q;
  logic          pvld_q, pvld_d;
  logic [NW-1:0] a_q, b_q;
  logic          range_q;
  logic [LW-1:0] la_q, la_d;
  logic [GW-1:0] sid_q, sid_d;
  logic [GW-1:0] src_q, src_d;
  logic          merge_q, merge_d;
  logic          inc_q, inc_d;
  logic [SW-1:0] src_size_q, src_size_d;
  logic [SW-1:0] size_q, size_d;
  logic [ACTION_W-1:0] action_q, action_d;
  logic          aj_q, aj_d;
  logic [GW:0]   ngid_q, ngid_d;
  logic [GW:0]   total_q, total_d;
  logic [CFG_W-1:0] node_count_q;

  logic          out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic          out_load;

  logic          accept;
  logic [NW-1:0] in_a, in_b;
  logic          in_range;
  logic          va, vb;
  logic [GW-1:0] la, lb;
  logic          relabel;
  logic [GW-1:0] eff_label;
  logic          eff_valid;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign in_a            = NW'(s_axis_tdata_i[NODE_ID_W-1:0]);
  assign in_b            = NW'(s_axis_tdata_i[2*NODE_ID_W-1:NODE_ID_W]);
  assign in_range        = (32'(s_axis_tdata_i[NODE_ID_W-1:0]) < NODES) &&
                           (32'(s_axis_tdata_i[2*NODE_ID_W-1:NODE_ID_W]) < NODES);

  assign va = la_q[GW];
  assign la = la_q[GW-1:0];
  assign vb = nm_rdata_q[GW];
  assign lb = nm_rdata_q[GW-1:0];

  assign relabel   = merge_q && nm_rdata_q[GW] && (nm_rdata_q[GW-1:0] == src_q);
  assign eff_label = relabel ? sid_q : nm_rdata_q[GW-1:0];
  assign eff_valid = nm_rdata_q[GW];

  assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready_i);

  always_comb begin
    out_data_d = '0;
    out_data_d[1:0]   = action_q;
    out_data_d[10:2]  = SET_ID_W'(sid_q);
    out_data_d[21:11] = SET_SIZE_W'(size_q);
    out_data_d[31:22] = LIVE_SETS_W'(total_q);
    out_data_d[32]    = aj_q;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pvld_d     = 1'b0;
    la_d       = la_q;
    sid_d      = sid_q;
    src_d      = src_q;
    merge_d    = merge_q;
    inc_d      = inc_q;
    src_size_d = src_size_q;
    size_d     = size_q;
    action_d   = action_q;
    aj_d       = aj_q;
    ngid_d     = ngid_q;
    total_d    = total_q;
    nm_we      = 1'b0;
    nm_waddr   = cnt_q;
    nm_wdata   = '0;
    nm_raddr   = cnt_q;
    gm_we      = 1'b0;
    gm_waddr   = sid_q;
    gm_wdata   = size_q;
    gm_raddr   = sid_q;

    unique case (state_q)
      S_CLEAR: begin
        nm_we    = 1'b1;
        nm_waddr = cnt_q;
        nm_wdata = '0;
        cnt_d    = cnt_q + NW'(1);
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        nm_raddr = in_a;
        if (accept) begin
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        la_d     = nm_rdata_q;
        nm_raddr = b_q;
        state_d  = S_RDB;
      end
      S_RDB: begin
        merge_d  = 1'b0;
        inc_d    = 1'b0;
        action_d = ACT_NONE;
        sid_d    = '0;
        size_d   = '0;
        aj_d     = 1'b0;
        state_d  = S_OUT;
        if (range_q) begin
          if (va && vb) begin
            if (la == lb) begin
              sid_d    = la;
              gm_raddr = la;
              state_d  = S_GSZ;
            end else begin
              sid_d    = (la < lb) ? la : lb;
              src_d    = (la < lb) ? lb : la;
              gm_raddr = (la < lb) ? lb : la;
              merge_d  = 1'b1;
              action_d = ACT_MERGE;
              if (total_q != '0) begin
                total_d = total_q - (GW+1)'(1);
              end
              state_d  = S_GSRC;
            end
          end else if (!va && !vb) begin
            if ((a_q != b_q) && (32'(ngid_q) < GROUPS)) begin
              sid_d    = ngid_q[GW-1:0];
              nm_we    = 1'b1;
              nm_waddr = a_q;
              nm_wdata = {1'b1, ngid_q[GW-1:0]};
              gm_we    = 1'b1;
              gm_waddr = ngid_q[GW-1:0];
              gm_wdata = SW'(2);
              size_d   = SW'(2);
              ngid_d   = ngid_q + (GW+1)'(1);
              total_d  = total_q + (GW+1)'(1);
              action_d = ACT_NEW;
              state_d  = S_WRB;
            end
          end else begin
            sid_d    = va ? la : lb;
            gm_raddr = va ? la : lb;
            nm_we    = 1'b1;
            nm_waddr = va ? b_q : a_q;
            nm_wdata = {1'b1, (va ? la : lb)};
            inc_d    = 1'b1;
            action_d = ACT_JOIN;
            state_d  = S_GSZ;
          end
        end
      end
      S_WRB: begin
        nm_we    = 1'b1;
        nm_waddr = b_q;
        nm_wdata = {1'b1, sid_q};
        cnt_d    = '0;
        aj_d     = 1'b1;
        state_d  = S_SCAN;
      end
      S_GSRC: begin
        src_size_d = gm_rdata_q;
        gm_raddr   = sid_q;
        state_d    = S_GSZ;
      end
      S_GSZ: begin
        size_d   = gm_rdata_q + (merge_q ? src_size_q : SW'(inc_q));
        gm_we    = 1'b1;
        gm_waddr = sid_q;
        gm_wdata = gm_rdata_q + (merge_q ? src_size_q : SW'(inc_q));
        cnt_d    = '0;
        aj_d     = 1'b1;
        state_d  = S_SCAN;
      end
      S_SCAN, S_DRAIN: begin
        if (pvld_q) begin
          if (relabel) begin
            nm_we    = 1'b1;
            nm_waddr = pidx_q;
            nm_wdata = {1'b1, sid_q};
          end
          if ((CW'(pidx_q) < CW'(node_count_q)) && !(eff_valid && (eff_label == sid_q))) begin
            aj_d = 1'b0;
          end
        end
        if (state_q == S_SCAN) begin
          nm_raddr = cnt_q;
          pvld_d   = 1'b1;
          cnt_d    = cnt_q + NW'(1);
          if (cnt_q == LAST_IDX) begin
            cnt_d   = '0;
            state_d = S_DRAIN;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) begin
      node_mem[nm_waddr] <= nm_wdata;
    end
    nm_rdata_q <= node_mem[nm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (gm_we) begin
      grp_mem[gm_waddr] <= gm_wdata;
    end
    gm_rdata_q <= grp_mem[gm_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      pvld_q       <= 1'b0;
      ngid_q       <= '0;
      total_q      <= '0;
      node_count_q <= NODE_COUNT_RST;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pvld_q  <= pvld_d;
      ngid_q  <= ngid_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q     <= in_a;
      b_q     <= in_b;
      range_q <= in_range;
    end
    pidx_q     <= cnt_q;
    la_q       <= la_d;
    sid_q      <= sid_d;
    src_q      <= src_d;
    merge_q    <= merge_d;
    inc_q      <= inc_d;
    src_size_q <= src_size_d;
    size_q     <= size_d;
    action_q   <= action_d;
    aj_q       <= aj_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  a_ngid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ngid_q) <= GROUPS)
    else $error("set id counter beyond GROUPS");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= ngid_q)
    else $error("live set count exceeds sets opened");

  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && out_vld_q && !m_axis_tready_i |=> (state_q == S_OUT))
    else $error("result dropped while output word stalled");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> !s_axis_tready_o)
    else $error("word taken during label walk");

endmodule

`default_nettype wire

>>> tb/sv/edge_driven_set_labeling_test.sv
// Self-checking testbench for edge_driven_set_labeling: edges are streamed in and
// every result word is checked against a local model of node labels and set sizes.
// Depends on edsl_pkg and the edge_driven_set_labeling RTL.
`timescale 1ns / 100ps

module edge_driven_set_labeling_test;
  import edsl_pkg::*;

  localparam int unsigned NODES  = NODES_DEF;
  localparam int unsigned GROUPS = GROUPS_DEF;

  typedef struct packed {
    logic                   all_joined;
    logic [LIVE_SETS_W-1:0] live_sets;
    logic [SET_SIZE_W-1:0]  set_size;
    logic [SET_ID_W-1:0]    set_id;
    logic [ACTION_W-1:0]    action;
  } outcome_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  int unsigned node_tag [NODES];
  bit          node_set [NODES];
  int unsigned set_members [GROUPS];
  int unsigned next_set = 0;
  int unsigned live_count = 0;
  int unsigned node_limit = 32'(NODE_COUNT_RST);

  outcome_t outcome_q [$];
  int       mismatches = 0;
  bit       gaps_on = 1'b0;

  edge_driven_set_labeling dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit covers_all(input int unsigned sid);
    int unsigned lim;
    lim = (node_limit > NODES) ? NODES : node_limit;
    for (int unsigned i = 0; i < lim; i++) begin
      if (!node_set[i] || node_tag[i] != sid) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Returns 1 when the edge names a set afterwards.
  function automatic bit apply_edge(input logic [NODE_ID_W-1:0] a, b, output outcome_t o);
    int unsigned la, lb, tgt, src, sid;
    int unsigned joiner, holder;
    bit named;
    logic [ACTION_W-1:0] act;
    act = ACT_NONE;
    sid = 0;
    named = 1'b0;
    if (node_set[a] && node_set[b]) begin
      la = node_tag[a];
      lb = node_tag[b];
      if (la == lb) begin
        sid = la;
      end else begin
        tgt = (la < lb) ? la : lb;
        src = (la < lb) ? lb : la;
        for (int i = 0; i < NODES; i++) begin
          if (node_set[i] && node_tag[i] == src) node_tag[i] = tgt;
        end
        set_members[tgt] += set_members[src];
        set_members[src] = 0;
        if (live_count > 0) live_count--;
        sid = tgt;
        act = ACT_MERGE;
      end
      named = 1'b1;
    end else if (!node_set[a] && !node_set[b]) begin
      if (a != b && next_set < GROUPS) begin
        sid = next_set;
        node_tag[a] = sid;
        node_tag[b] = sid;
        node_set[a] = 1'b1;
        node_set[b] = 1'b1;
        set_members[sid] = 2;
        next_set++;
        live_count++;
        act = ACT_NEW;
        named = 1'b1;
      end
    end else begin
      joiner = node_set[a] ? 32'(b) : 32'(a);
      holder = node_set[a] ? 32'(a) : 32'(b);
      sid = node_tag[holder];
      node_tag[joiner] = sid;
      node_set[joiner] = 1'b1;
      set_members[sid]++;
      act = ACT_JOIN;
      named = 1'b1;
    end
    o.action     = act;
    o.set_id     = named ? sid[SET_ID_W-1:0] : '0;
    o.set_size   = named ? set_members[sid][SET_SIZE_W-1:0] : '0;
    o.live_sets  = live_count[LIVE_SETS_W-1:0];
    o.all_joined = named && covers_all(sid);
    return named;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 40) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 40);
    return $urandom_range(200, 1500);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 6);
    if (r < 99) return $urandom_range(7, 60);
    return $urandom_range(200, 1500);
  endfunction

  function automatic void pick_edge(input int unsigned lo, hi,
                                    output logic [NODE_ID_W-1:0] a, b);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      a = NODE_ID_W'($urandom);
      b = NODE_ID_W'($urandom);
    end else begin
      a = NODE_ID_W'($urandom_range(lo, hi));
      b = (r < 16) ? a : NODE_ID_W'($urandom_range(lo, hi));
    end
  endfunction

  task automatic send_edge(input logic [NODE_ID_W-1:0] a, b);
    outcome_t want;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - 2 * NODE_ID_W){1'b0}}, b, a};
    do @(posedge clk_i); while (!s_tready);
    void'(apply_edge(a, b, want));
    outcome_q.push_back(want);
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic push_edge(input logic [NODE_ID_W-1:0] a, b);
    send_edge(a, b);
    sender_gap();
  endtask

  task automatic await_outcomes();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] v);
    await_outcomes();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    node_limit = 32'(v);
  endtask

  task automatic run_random(input int count, input int unsigned lo, hi);
    logic [NODE_ID_W-1:0] a, b;
    for (int done = 0; done < count; done++) begin
      pick_edge(lo, hi, a, b);
      send_edge(a, b);
      sender_gap();
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    push_edge(10'd5, 10'd5);
    push_edge(10'd0, 10'd1);
    push_edge(10'd2, 10'd1);
    push_edge(10'd1, 10'd3);
    push_edge(10'd0, 10'd2);
    push_edge(10'd1023, 10'd1022);
    push_edge(10'd1023, 10'd1023);
    push_edge(10'd700, 10'd701);
    push_edge(10'd1023, 10'd3);
    push_edge(10'd700, 10'd1022);
    push_edge(10'd6, 10'd7);
    push_edge(10'd8, 10'd9);
    push_edge(10'd9, 10'd6);
    push_edge(10'd6, 10'd0);
    write_node_count(11'd0);
    push_edge(10'd0, 10'd1);
    push_edge(10'd10, 10'd10);
    push_edge(10'd10, 10'd11);
    write_node_count(11'd2047);
    push_edge(10'd11, 10'd0);
    push_edge(10'd512, 10'd511);
    write_node_count(11'd2);
    push_edge(10'd1, 10'd0);
    push_edge(10'd12, 10'd1);
  endtask

  task automatic test_dense_low();
    write_node_count(11'd16);
    gaps_on = 1'b1;
    run_random(130, 0, 31);
  endtask

  task automatic test_pair_count();
    write_node_count(11'd2);
    gaps_on = 1'b0;
    run_random(70, 0, 7);
  endtask

  task automatic test_wide_spread();
    write_node_count(11'd1024);
    gaps_on = 1'b1;
    run_random(75, 256, 767);
    await_outcomes();
    run_random(75, 256, 767);
  endtask

  task automatic test_varied_counts();
    int unsigned lo;
    gaps_on = 1'b1;
    repeat (4) begin
      write_node_count(CFG_W'($urandom_range(2, 1024)));
      lo = $urandom_range(0, NODES - 64);
      run_random(25, lo, lo + 63);
    end
  endtask

  task automatic test_count_saturation();
    write_node_count(11'd2047);
    gaps_on = 1'b1;
    run_random(130, 0, NODES - 1);
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
      if (outcome_q.size() == 0) begin
        $error("result word with no edge pending");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (got.action != want.action) begin
          $error("action: expected %0d, got %0d", want.action, got.action);
          mismatches++;
        end
        if (got.set_id != want.set_id) begin
          $error("set_id: expected %0d, got %0d", want.set_id, got.set_id);
          mismatches++;
        end
        if (got.set_size != want.set_size) begin
          $error("set_size: expected %0d, got %0d", want.set_size, got.set_size);
          mismatches++;
        end
        if (got.live_sets != want.live_sets) begin
          $error("live_sets: expected %0d, got %0d", want.live_sets, got.live_sets);
          mismatches++;
        end
        if (got.all_joined != want.all_joined) begin
          $error("all_joined: expected %0d, got %0d", want.all_joined, got.all_joined);
          mismatches++;
        end
      end
    end
  end

  initial begin : drive_ready
    int unsigned n;
    forever begin
      @(negedge clk_i);
      m_tready <= 1'b1;
      if ($urandom_range(0, 15) == 0) begin
        repeat (3000) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(0, 60)) @(negedge clk_i);
        n = stall_len();
        if (n > 0) begin
          @(negedge clk_i);
          m_tready <= 1'b0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    #160_000_000;
    $display("FAIL edge_driven_set_labeling");
    $finish;
  end

  initial begin : run_tests
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_dense_low();
    test_pair_count();
    test_wide_spread();
    test_varied_counts();
    test_count_saturation();
    await_outcomes();
    repeat (NODES + 16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS edge_driven_set_labeling");
    end else begin
      $display("FAIL edge_driven_set_labeling");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/edsl_pkg.sv
rtl/edge_driven_set_labeling.sv
tb/sv/edge_driven_set_labeling_test.sv
